/* rtl/tnfa_pkg.sv */
// Shared constants and types for the Thompson NFA matcher.
package tnfa_pkg;
	localparam int NUM_NODES = 64;
	localparam int IDX_W = 6;
	localparam int NODE_W = 22;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_FEED  = 2'd2;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_SPLIT = 2'd1;
	localparam logic [1:0] KIND_FINAL = 2'd2;

	typedef struct packed {
		logic [5:0] alt;
		logic [5:0] nxt;
		logic [7:0] byte_val;
		logic [1:0] kind;
	} node_t;

	typedef logic [NUM_NODES-1:0] set_t;
endpackage

/* rtl/tnfa_table.sv */
// Node table memory with one write port and one registered read port.
module tnfa_table import tnfa_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  node_t            wdata,
	input  logic [IDX_W-1:0] raddr,
	output node_t            rdata
);
	node_t mem [NUM_NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/thompson_nfa_matcher.sv */
// Every pass over the node table reads all 64 nodes in turn, takes the last read and then closes
// the pass. A load, start or idle word runs one closure pass plus one more for each pass that grew
// the set; a byte adds one step pass and then a second closure of the same kind. The result word is
// registered in the done state after the last pass closes.
// Throughput: one word at a time; the next input word is accepted the cycle after the result
// word is taken. Reset clears the active set and the control state; the table is not cleared.
module thompson_nfa_matcher import tnfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: mode, entry_index, entry_kind, entry_byte, entry_next, entry_alt, symbol
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: matched, alive
	output logic [7:0]  m_tdata
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLOS  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [7:0]       sym_q;
	set_t             act_q, clos_q, nxt_q;
	logic             grew_q, fin_q, after_q;
	logic [IDX_W:0]   cnt_q;
	logic             rd_v_q;
	logic [IDX_W-1:0] rd_idx_q;
	node_t            rnode;
	logic             out_v_q;
	logic [1:0]       out_q;

	wire accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_q};

	node_t wnode;
	assign wnode = '{alt: s_tdata[29:24], nxt: s_tdata[23:18],
		byte_val: s_tdata[17:10], kind: s_tdata[9:8]};

	tnfa_table u_table (
		.clk(clk), .we(accept && s_tdata[1:0] == MODE_LOAD),
		.waddr(s_tdata[7:2]), .wdata(wnode),
		.raddr(cnt_q[IDX_W-1:0]), .rdata(rnode)
	);

	wire scanning = !cnt_q[IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q <= '0;
			out_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sym_q <= s_tdata[37:30];
						if (s_tdata[1:0] == MODE_START) begin
							act_q <= set_t'(1) << s_tdata[7:2];
							clos_q <= set_t'(1) << s_tdata[7:2];
						end else begin
							clos_q <= act_q;
						end
						after_q <= (s_tdata[1:0] != MODE_FEED);
						cnt_q <= '0;
						grew_q <= 1'b0;
						fin_q <= 1'b0;
						state_q <= ST_CLOS;
					end
				end
				ST_CLOS, ST_STEP: begin
					rd_v_q <= scanning;
					if (scanning) begin
						rd_idx_q <= cnt_q[IDX_W-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_v_q && clos_q[rd_idx_q]) begin
						if (state_q == ST_CLOS) begin
							if (rnode.kind == KIND_SPLIT) begin
								if (!clos_q[rnode.nxt] || !clos_q[rnode.alt]) grew_q <= 1'b1;
								clos_q <= clos_q | (set_t'(1) << rnode.nxt)
									| (set_t'(1) << rnode.alt);
							end
							if (rnode.kind == KIND_FINAL) fin_q <= 1'b1;
						end else if (rnode.kind == KIND_BYTE && rnode.byte_val == sym_q) begin
							nxt_q <= nxt_q | (set_t'(1) << rnode.nxt);
						end
					end
					if (!scanning && !rd_v_q) begin
						cnt_q <= '0;
						grew_q <= 1'b0;
						if (state_q == ST_CLOS && grew_q) begin
							fin_q <= 1'b0;
						end else if (state_q == ST_CLOS && !after_q) begin
							nxt_q <= '0;
							state_q <= ST_STEP;
						end else if (state_q == ST_STEP) begin
							act_q <= nxt_q;
							clos_q <= nxt_q;
							after_q <= 1'b1;
							fin_q <= 1'b0;
							state_q <= ST_CLOS;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				default: begin
					out_q <= {|act_q, fin_q};
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* rtl/tnfa_checker.sv */
// Port-level checker for the matcher, bound to the top level.
module tnfa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output word dropped");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'd0) else $error("padding bits set");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind thompson_nfa_matcher tnfa_checker u_tnfa_checker (.*);
